FILE: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timeout queue: field widths,
// request kinds, result status codes and default sizes.
// ----------------------------------------------------------------------------
package stq_pkg;

  // default sizes
  localparam int SLOTS_DEF = 16;

  // field widths
  localparam int TICK_W  = 32;
  localparam int TAG_W   = 8;
  localparam int SLOT_W  = 4;   // slot_to_remove and result slot
  localparam int COUNT_W = 5;   // active_count
  localparam int STAT_W  = 3;
  localparam int OP_W    = 2;

  // stream data layout, lowest bit first
  localparam int IN_DATA_BITS  = TICK_W + SLOT_W + TAG_W + TICK_W;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = SLOT_W + STAT_W + COUNT_W;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // request kinds
  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POLL   = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_CREATED      = 3'd0,
    ST_FULL         = 3'd1,
    ST_REMOVED      = 3'd2,
    ST_EMPTY        = 3'd3,
    ST_TAG_MISMATCH = 3'd4,
    ST_NOT_FOUND    = 3'd5,
    ST_EXPIRED      = 3'd6,
    ST_NONE_DUE     = 3'd7
  } status_t;

endpackage

FILE: rtl/sorted_timeout_queue.sv
// ----------------------------------------------------------------------------
// sorted_timeout_queue
// Timeout slots kept in a deadline-sorted singly linked list held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the kind (create,
//   remove, poll), tdata the deadline, slot, owner tag and current tick.
//   Results leave on m_axis: slot, status and active count in tdata, tlast
//   on the final result of a request. Create and remove give one result,
//   a poll gives one result per expired head, or a single "none due".
//   Requests are taken one at a time; s_axis_tready is high whenever the
//   sequencer is idle, even while a result still waits in the output
//   register.
//   The sequencer steps through one list node per cycle against the
//   registered reads of the deadline/link RAMs; a poll step waits while
//   a result is held in a stalled output register.
//   Reset clears list head, count, busy and tag-valid flags at once; no
//   clearing pass over the RAMs is needed. A stalled m_axis receiver holds
//   the sequencer at its next result until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_timeout_queue #(
  parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: deadline[31:0], slot_to_remove[35:32], owner_tag[43:36], now[75:44]
  input  logic [stq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [stq_pkg::OP_W-1:0]        s_axis_tuser,
  // result channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: slot[3:0], status[6:4], active_count[11:7]
  output logic [stq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int CNT_W  = LINK_W;
  localparam logic [LINK_W-1:0] NONE = LINK_W'(SLOTS);

  // field offsets in the request data
  localparam int D_LO   = 0;
  localparam int T_LO   = D_LO + stq_pkg::TICK_W;
  localparam int G_LO   = T_LO + stq_pkg::SLOT_W;
  localparam int N_LO   = G_LO + stq_pkg::TAG_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_C_CMP  = 9'b000000010,
    S_C_LNK1 = 9'b000000100,
    S_C_LNK2 = 9'b000001000,
    S_R_TAG  = 9'b000010000,
    S_R_WALK = 9'b000100000,
    S_P_CHK  = 9'b001000000,
    S_P_LAST = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  // request fields
  logic [stq_pkg::TICK_W-1:0] in_deadline;
  logic [stq_pkg::SLOT_W-1:0] in_slot;
  logic [stq_pkg::TAG_W-1:0]  in_tag;
  logic [stq_pkg::TICK_W-1:0] in_now;
  stq_pkg::op_t               in_op;

  assign in_deadline = s_axis_tdata[D_LO +: stq_pkg::TICK_W];
  assign in_slot     = s_axis_tdata[T_LO +: stq_pkg::SLOT_W];
  assign in_tag      = s_axis_tdata[G_LO +: stq_pkg::TAG_W];
  assign in_now      = s_axis_tdata[N_LO +: stq_pkg::TICK_W];
  assign in_op       = stq_pkg::op_t'(s_axis_tuser);

  // control registers
  state_t              state, state_next;
  logic [LINK_W-1:0]   head, head_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [SLOTS-1:0]    busy, busy_next;
  logic [SLOTS-1:0]    tag_vld, tag_vld_next;
  logic                have_pend, have_pend_next;
  logic                out_valid;

  // working registers
  logic [IDX_W-1:0]           cur, cur_next;        // slot being created/removed
  logic [IDX_W-1:0]           prev, prev_next;      // list predecessor
  logic [LINK_W-1:0]          succ, succ_next;      // candidate successor
  logic                       at_head, at_head_next;
  logic [LINK_W-1:0]          t_next, t_next_next;  // link of removed slot
  logic [IDX_W-1:0]           pend, pend_next;      // expired slot awaiting output
  logic [stq_pkg::TICK_W-1:0] req_d, req_d_next;
  logic [stq_pkg::TAG_W-1:0]  req_tag, req_tag_next;
  logic [stq_pkg::TICK_W-1:0] now_q, now_q_next;
  logic [stq_pkg::SLOT_W-1:0] e_slot, e_slot_next;
  stq_pkg::status_t           e_status, e_status_next;

  // output register
  logic [stq_pkg::SLOT_W-1:0]  out_slot;
  stq_pkg::status_t            out_status;
  logic [stq_pkg::COUNT_W-1:0] out_count;
  logic                        out_last;

  // load strobe for the output register
  logic                        ld;
  logic [stq_pkg::SLOT_W-1:0]  ld_slot;
  stq_pkg::status_t            ld_status;
  logic                        ld_last;
  logic                        can_emit;

  // RAM ports
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [stq_pkg::TICK_W-1:0] rd_dl;
  logic [LINK_W-1:0]          rd_link;
  logic [stq_pkg::TAG_W-1:0]  rd_tag;
  logic                       link_we;
  logic [IDX_W-1:0]           link_wa;
  logic [LINK_W-1:0]          link_wd;
  logic                       slot_we;

  // lowest idle slot
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!busy[k]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
  end

  // memories: deadline, link and tag per slot
  stq_ram #(.WIDTH(stq_pkg::TICK_W), .DEPTH(SLOTS)) u_deadline_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (cur),
    .wr_data (req_d),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_dl)
  );

  stq_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_link)
  );

  stq_ram #(.WIDTH(stq_pkg::TAG_W), .DEPTH(SLOTS)) u_tag_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (cur),
    .wr_data (req_tag),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_tag)
  );

  assign can_emit      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  // sequencer
  always_comb begin
    logic [stq_pkg::TAG_W-1:0] stored_tag;
    logic                      adv;
    logic                      expired;

    state_next     = state;
    head_next      = head;
    count_next     = count;
    busy_next      = busy;
    tag_vld_next   = tag_vld;
    have_pend_next = have_pend;
    cur_next       = cur;
    prev_next      = prev;
    succ_next      = succ;
    at_head_next   = at_head;
    t_next_next    = t_next;
    pend_next      = pend;
    req_d_next     = req_d;
    req_tag_next   = req_tag;
    now_q_next     = now_q;
    e_slot_next    = e_slot;
    e_status_next  = e_status;

    rd_en     = 1'b0;
    rd_addr   = '0;
    link_we   = 1'b0;
    link_wa   = '0;
    link_wd   = '0;
    slot_we   = 1'b0;
    ld        = 1'b0;
    ld_slot   = '0;
    ld_status = stq_pkg::ST_CREATED;
    ld_last   = 1'b1;

    stored_tag = tag_vld[cur] ? rd_tag : '0;
    adv        = at_head ? !(req_d < rd_dl) : (req_d > rd_dl);
    expired    = (rd_dl < now_q);

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (in_op)
            stq_pkg::OP_CREATE: begin
              req_d_next   = in_deadline;
              req_tag_next = in_tag;
              if (!free_found) begin
                e_slot_next   = '0;
                e_status_next = stq_pkg::ST_FULL;
                state_next    = S_EMIT;
              end else begin
                cur_next     = free_idx;
                succ_next    = head;
                at_head_next = 1'b1;
                if (head == NONE) begin
                  state_next = S_C_LNK1;
                end else begin
                  rd_en      = 1'b1;
                  rd_addr    = IDX_W'(head);
                  state_next = S_C_CMP;
                end
              end
            end
            stq_pkg::OP_REMOVE: begin
              req_tag_next = in_tag;
              e_slot_next  = in_slot;
              if (head == NONE) begin
                e_status_next = stq_pkg::ST_EMPTY;
                state_next    = S_EMIT;
              end else if (32'(in_slot) >= 32'(SLOTS)) begin
                e_status_next = stq_pkg::ST_NOT_FOUND;
                state_next    = S_EMIT;
              end else begin
                cur_next   = IDX_W'(in_slot);
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(in_slot);
                state_next = S_R_TAG;
              end
            end
            stq_pkg::OP_POLL: begin
              now_q_next     = in_now;
              have_pend_next = 1'b0;
              if (head == NONE) begin
                e_slot_next   = '0;
                e_status_next = stq_pkg::ST_NONE_DUE;
                state_next    = S_EMIT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(head);
                state_next = S_P_CHK;
              end
            end
            default: ; // unused kind: dropped, no result
          endcase
        end
      end

      // compare new deadline against node succ; step on or stop
      S_C_CMP: begin
        if (adv) begin
          prev_next    = IDX_W'(succ);
          succ_next    = rd_link;
          at_head_next = 1'b0;
          if (rd_link == NONE) begin
            state_next = S_C_LNK1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(rd_link);
          end
        end else begin
          state_next = S_C_LNK1;
        end
      end

      // write the new slot and its forward link
      S_C_LNK1: begin
        slot_we           = 1'b1;
        link_we           = 1'b1;
        link_wa           = cur;
        link_wd           = succ;
        tag_vld_next[cur] = 1'b1;
        if (at_head) begin
          head_next       = LINK_W'(cur);
          busy_next[cur]  = 1'b1;
          count_next      = count + 1'b1;
          e_slot_next     = stq_pkg::SLOT_W'(cur);
          e_status_next   = stq_pkg::ST_CREATED;
          state_next      = S_EMIT;
        end else begin
          state_next = S_C_LNK2;
        end
      end

      // point the predecessor at the new slot
      S_C_LNK2: begin
        link_we        = 1'b1;
        link_wa        = prev;
        link_wd        = LINK_W'(cur);
        busy_next[cur] = 1'b1;
        count_next     = count + 1'b1;
        e_slot_next    = stq_pkg::SLOT_W'(cur);
        e_status_next  = stq_pkg::ST_CREATED;
        state_next     = S_EMIT;
      end

      // tag and busy check; head removal done here
      S_R_TAG: begin
        if (stored_tag != req_tag) begin
          e_status_next = stq_pkg::ST_TAG_MISMATCH;
          state_next    = S_EMIT;
        end else if (!busy[cur]) begin
          e_status_next = stq_pkg::ST_NOT_FOUND;
          state_next    = S_EMIT;
        end else if (head == LINK_W'(cur)) begin
          head_next      = rd_link;
          busy_next[cur] = 1'b0;
          count_next     = count - 1'b1;
          e_status_next  = stq_pkg::ST_REMOVED;
          state_next     = S_EMIT;
        end else begin
          t_next_next = rd_link;
          prev_next   = IDX_W'(head);
          rd_en       = 1'b1;
          rd_addr     = IDX_W'(head);
          state_next  = S_R_WALK;
        end
      end

      // find the predecessor and splice around the slot
      S_R_WALK: begin
        if (rd_link == LINK_W'(cur)) begin
          link_we        = 1'b1;
          link_wa        = prev;
          link_wd        = t_next;
          busy_next[cur] = 1'b0;
          count_next     = count - 1'b1;
          e_status_next  = stq_pkg::ST_REMOVED;
          state_next     = S_EMIT;
        end else if (rd_link == NONE) begin
          e_status_next = stq_pkg::ST_NOT_FOUND;
          state_next    = S_EMIT;
        end else begin
          prev_next = IDX_W'(rd_link);
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(rd_link);
        end
      end

      // check head; the previous pop goes out once its successor is known
      S_P_CHK: begin
        if (can_emit) begin
          if (have_pend) begin
            ld        = 1'b1;
            ld_slot   = stq_pkg::SLOT_W'(pend);
            ld_status = stq_pkg::ST_EXPIRED;
            ld_last   = !expired;
          end else if (!expired) begin
            ld        = 1'b1;
            ld_slot   = '0;
            ld_status = stq_pkg::ST_NONE_DUE;
          end
          if (expired) begin
            pend_next                 = IDX_W'(head);
            have_pend_next            = 1'b1;
            head_next                 = rd_link;
            busy_next[IDX_W'(head)]   = 1'b0;
            count_next                = count - 1'b1;
            if (rd_link == NONE) begin
              state_next = S_P_LAST;
            end else begin
              rd_en   = 1'b1;
              rd_addr = IDX_W'(rd_link);
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      // list ran dry: the last pop is the final result
      S_P_LAST: begin
        if (can_emit) begin
          ld         = 1'b1;
          ld_slot    = stq_pkg::SLOT_W'(pend);
          ld_status  = stq_pkg::ST_EXPIRED;
          state_next = S_IDLE;
        end
      end

      // single result
      S_EMIT: begin
        if (can_emit) begin
          ld         = 1'b1;
          ld_slot    = e_slot;
          ld_status  = e_status;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NONE;
      count     <= '0;
      busy      <= '0;
      tag_vld   <= '0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      busy      <= busy_next;
      tag_vld   <= tag_vld_next;
      have_pend <= have_pend_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    prev     <= prev_next;
    succ     <= succ_next;
    at_head  <= at_head_next;
    t_next   <= t_next_next;
    pend     <= pend_next;
    req_d    <= req_d_next;
    req_tag  <= req_tag_next;
    now_q    <= now_q_next;
    e_slot   <= e_slot_next;
    e_status <= e_status_next;
    if (ld) begin
      out_slot   <= ld_slot;
      out_status <= ld_status;
      out_count  <= stq_pkg::COUNT_W'(count);
      out_last   <= ld_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = stq_pkg::OUT_DATA_W'({out_count, out_status, out_slot});

`ifndef NO_ASSERTIONS
  // linked count tracks the busy flags
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    $countones(busy) == int'(count))
    else $error("count does not match busy slots");

  // empty list exactly when count is zero
  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (head == NONE) == (count == '0))
    else $error("head marker and count disagree");

  // a linked head is always a busy slot
  a_head_busy: assert property (@(posedge clk) disable iff (rst)
    (head != NONE) |-> busy[IDX_W'(head)])
    else $error("head slot is not busy");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ld |-> (!out_valid || m_axis_tready))
    else $error("output register loaded while stalled");

  // a new request only starts from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> (state == S_IDLE))
    else $error("request taken outside idle");
`endif

endmodule

FILE: rtl/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int WIDTH = stq_pkg::TICK_W,
  parameter int DEPTH = stq_pkg::SLOTS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sim/tb_sorted_timeout_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_timeout_queue
// Self-checking bench for the sorted timeout queue. A behavioral copy of the
// deadline-sorted slot list predicts every result of each accepted request.
// Results are matched in order, field by field. Directed requests cover the
// list edges first. Random create, remove and poll sequences follow, with
// idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module tb_sorted_timeout_queue;
  import stq_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [4:0] NO_SLOT = 5'(SLOTS);     // end-of-list marker
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;  // unused kind, ignored
  localparam int REQ_TARGET = 380;
  localparam int QUIET_TAIL = 60;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } timeout_result_t;

  // Behavioral timer list plus the results it still owes
  class timer_list_model;
    logic [TICK_W-1:0] dl [SLOTS];
    logic [TAG_W-1:0]  tag [SLOTS];
    logic              busy [SLOTS];
    logic [4:0]        nxt [SLOTS];
    logic [4:0]        head;
    logic [COUNT_W-1:0] count;
    timeout_result_t   results_owed[$];
    int                errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        dl[i] = '0;
        tag[i] = '0;
        busy[i] = 1'b0;
        nxt[i] = '0;
      end
      head = NO_SLOT;
      count = '0;
      errors = 0;
    endfunction

    function void owe(logic [SLOT_W-1:0] s, status_t st, logic lst);
      timeout_result_t r;
      r.slot = s;
      r.status = st;
      r.count = count;
      r.last = lst;
      results_owed.push_back(r);
    endfunction

    function void report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endfunction

    function int pending();
      return results_owed.size();
    endfunction

    // Apply one accepted request and queue its results
    function void take_request(logic [OP_W-1:0] op, logic [TICK_W-1:0] d,
                               logic [SLOT_W-1:0] t, logic [TAG_W-1:0] tg,
                               logic [TICK_W-1:0] now);
      int free_slot;
      int k;
      logic [4:0] p, n;
      logic found;
      free_slot = -1;
      k = 0;
      found = 1'b0;
      case (op)
        OP_CREATE: begin
          for (int i = 0; i < SLOTS; i++)
            if (!busy[i]) begin
              free_slot = i;
              break;
            end
          if (free_slot < 0) begin
            owe('0, ST_FULL, 1'b1);
          end else begin
            dl[free_slot] = d;
            tag[free_slot] = tg;
            busy[free_slot] = 1'b1;
            count++;
            // strictly earlier than head goes in front
            if (head == NO_SLOT || d < dl[head]) begin
              nxt[free_slot] = head;
              head = 5'(free_slot);
            end else begin
              p = head;
              for (int g = 0; g < SLOTS; g++) begin
                n = nxt[p];
                if (n == NO_SLOT || !(d > dl[n])) break;
                p = n;
              end
              nxt[free_slot] = nxt[p];
              nxt[p] = 5'(free_slot);
            end
            owe(SLOT_W'(free_slot), ST_CREATED, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (head == NO_SLOT) begin
            owe(t, ST_EMPTY, 1'b1);
          end else if (tag[t] != tg) begin
            owe(t, ST_TAG_MISMATCH, 1'b1);
          end else if (5'(t) == head) begin
            head = nxt[t];
            busy[t] = 1'b0;
            count--;
            owe(t, ST_REMOVED, 1'b1);
          end else begin
            p = head;
            for (int g = 0; g < SLOTS; g++) begin
              n = nxt[p];
              if (n == NO_SLOT) break;
              if (n == 5'(t)) begin
                nxt[p] = nxt[t];
                found = 1'b1;
                break;
              end
              p = n;
            end
            if (found) begin
              busy[t] = 1'b0;
              count--;
              owe(t, ST_REMOVED, 1'b1);
            end else begin
              owe(t, ST_NOT_FOUND, 1'b1);
            end
          end
        end
        OP_POLL: begin
          // pop every head strictly below now
          while (head != NO_SLOT && dl[head] < now && k < SLOTS) begin
            p = head;
            head = nxt[p];
            busy[p] = 1'b0;
            count--;
            owe(SLOT_W'(p), ST_EXPIRED, 1'b0);
            k++;
          end
          if (k == 0) owe('0, ST_NONE_DUE, 1'b1);
          else results_owed[results_owed.size()-1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest owed one
    function void match_result(logic [OUT_DATA_W-1:0] data, logic tlast);
      timeout_result_t exp_r;
      if (results_owed.size() == 0) begin
        report($sformatf("unexpected result data=%h last=%b", data, tlast));
        return;
      end
      exp_r = results_owed.pop_front();
      if (data[SLOT_W-1:0] !== exp_r.slot)
        report($sformatf("slot %0d, want %0d", data[SLOT_W-1:0], exp_r.slot));
      if (data[SLOT_W+STAT_W-1:SLOT_W] !== exp_r.status)
        report($sformatf("status %0d, want %0d", data[SLOT_W+STAT_W-1:SLOT_W],
                         exp_r.status));
      if (data[OUT_DATA_BITS-1:SLOT_W+STAT_W] !== exp_r.count)
        report($sformatf("active_count %0d, want %0d",
                         data[OUT_DATA_BITS-1:SLOT_W+STAT_W], exp_r.count));
      if (data[OUT_DATA_W-1:OUT_DATA_BITS] !== '0)
        report($sformatf("pad bits %h not zero", data[OUT_DATA_W-1:OUT_DATA_BITS]));
      if (tlast !== exp_r.last)
        report($sformatf("tlast %b, want %b", tlast, exp_r.last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  timer_list_model model;
  logic            src_idle_on;
  logic            sink_idle_on;
  logic [TICK_W-1:0] tick;
  int              req_count;

  sorted_timeout_queue #(.SLOTS(SLOTS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      model.match_result(m_axis_tdata, m_axis_tlast);
  end

  // receiver with random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Drive one request; starts and ends at a falling edge
  task automatic send_request(logic [OP_W-1:0] op, logic [TICK_W-1:0] d,
                              logic [SLOT_W-1:0] t, logic [TAG_W-1:0] tg,
                              logic [TICK_W-1:0] now);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W-IN_DATA_BITS){1'b0}}, now, tg, t, d};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model.take_request(op, d, t, tg, now);
    if (op != OP_RESERVED) req_count++;
    @(negedge clk);
  endtask

  // mostly near the running tick, with extremes mixed in
  function automatic logic [TICK_W-1:0] pick_deadline();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return tick + TICK_W'($urandom_range(0, 300));
    if (r < 85) return TICK_W'($urandom);
    if (r < 90) return '0;
    if (r < 95) return '1;
    return tick;
  endfunction

  // stimulus
  initial begin
    int r;
    int s;
    logic [SLOT_W-1:0] pick;
    logic got;
    model = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_CREATE;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    tick = '0;
    req_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty list, edge deadlines, equal deadlines, tag checks
    send_request(OP_POLL, '0, '0, '0, '0);
    send_request(OP_REMOVE, '0, 4'hF, 8'hFF, '0);
    send_request(OP_CREATE, 32'hFFFF_FFFF, '0, 8'hFF, '0);
    send_request(OP_CREATE, 32'h0, '0, 8'h00, '0);
    send_request(OP_CREATE, 32'h8000_0000, '0, 8'hA5, '0);
    send_request(OP_CREATE, 32'h8000_0000, '0, 8'h5A, '0);   // ties go first
    send_request(OP_CREATE, 32'h0, '0, 8'h01, '0);           // ties with head
    send_request(OP_REMOVE, '0, 4'd2, 8'h00, '0);            // wrong tag
    send_request(OP_REMOVE, '0, 4'd7, 8'h00, '0);            // idle slot
    send_request(OP_REMOVE, '0, 4'd2, 8'hA5, '0);            // middle entry
    send_request(OP_REMOVE, '0, 4'd2, 8'hA5, '0);            // freed, old tag
    send_request(OP_RESERVED, '1, 4'hF, 8'hFF, '1);
    send_request(OP_POLL, '0, '0, '0, 32'h0);
    send_request(OP_POLL, '0, '0, '0, 32'h1);
    send_request(OP_POLL, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, '0, 4'd0, 8'hFF, '0);            // head entry
    send_request(OP_CREATE, 32'h1234_5678, '0, 8'h3C, '0);
    send_request(OP_REMOVE, '0, 4'd0, 8'h3C, '0);            // only entry

    // random sequences
    while (req_count < REQ_TARGET) begin
      if (req_count % 30 == 0) begin
        src_idle_on  = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (req_count >= REQ_TARGET - QUIET_TAIL) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_request(OP_CREATE, pick_deadline(), 4'($urandom), 8'($urandom),
                     TICK_W'($urandom));
      end else if (r < 64) begin
        // remove: live slot with its tag, wrong tag, or idle slot
        s = $urandom_range(0, SLOTS - 1);
        got = 1'b0;
        pick = 4'(s);
        for (int i = 0; i < SLOTS; i++) begin
          if (!got && model.busy[(s + i) % SLOTS] == (r < 58)) begin
            pick = 4'((s + i) % SLOTS);
            got = 1'b1;
          end
        end
        if (r >= 50 && r < 58)
          send_request(OP_REMOVE, TICK_W'($urandom), pick,
                       model.tag[pick] ^ 8'($urandom_range(1, 255)), '0);
        else
          send_request(OP_REMOVE, TICK_W'($urandom), pick, model.tag[pick],
                       TICK_W'($urandom));
      end else if (r < 84) begin
        tick = tick + TICK_W'($urandom_range(0, 80));
        send_request(OP_POLL, TICK_W'($urandom), 4'($urandom), 8'($urandom), tick);
      end else if (r < 88) begin
        send_request(OP_POLL, '0, '0, '0,
                     ($urandom_range(0, 1) != 0) ? TICK_W'($urandom) : '1);
      end else if (r < 92) begin
        // fill the table, overflow once, maybe flush
        while (model.count < COUNT_W'(SLOTS))
          send_request(OP_CREATE, pick_deadline(), '0, 8'($urandom), '0);
        send_request(OP_CREATE, pick_deadline(), '0, 8'($urandom), '0);
        if ($urandom_range(0, 1) != 0) send_request(OP_POLL, '0, '0, '0, '1);
      end else if (r < 97) begin
        send_request(OP_RESERVED, TICK_W'($urandom), 4'($urandom), 8'($urandom),
                     TICK_W'($urandom));
      end else begin
        send_request(2'($urandom_range(0, 2)), TICK_W'($urandom), 4'($urandom),
                     8'($urandom), TICK_W'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then allow a full poll walk of settling time
    while (model.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (model.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
